// ----- rtl/lbmnm_pkg.sv -----
// Shared types and constants for the D2Q9 node moment block.
`default_nettype none

package lbmnm_pkg;

    localparam int CFG_W          = 32;
    localparam int VALUE_W_DEF    = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ACC_GUARD      = 8;
    localparam int CFG_ADDR_W     = 1;
    localparam int DIRECTION_W    = 4;

    localparam logic [CFG_W-1:0] LATTICE_SPEED_RST  = 32'd65536;
    localparam logic [CFG_W-1:0] SOUND_SPEED_SQ_RST = 32'd21845;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LATTICE_SPEED  = 1'b0,
        CFG_SOUND_SPEED_SQ = 1'b1
    } cfg_idx_t;

    localparam logic [DIRECTION_W-1:0] DIR_REST  = 4'd0;
    localparam logic [DIRECTION_W-1:0] DIR_EAST  = 4'd1;
    localparam logic [DIRECTION_W-1:0] DIR_NORTH = 4'd2;
    localparam logic [DIRECTION_W-1:0] DIR_WEST  = 4'd3;
    localparam logic [DIRECTION_W-1:0] DIR_SOUTH = 4'd4;
    localparam logic [DIRECTION_W-1:0] DIR_NE    = 4'd5;
    localparam logic [DIRECTION_W-1:0] DIR_NW    = 4'd6;
    localparam logic [DIRECTION_W-1:0] DIR_SW    = 4'd7;
    localparam logic [DIRECTION_W-1:0] DIR_SE    = 4'd8;

    typedef enum logic {
        MD_MUL = 1'b0,
        MD_DIV = 1'b1
    } md_op_t;

    typedef struct packed {
        logic   start;
        md_op_t op;
    } md_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } md_stat_t;

    typedef enum logic [3:0] {
        ST_ACC,
        ST_MULX,
        ST_MULX_W,
        ST_DIVX,
        ST_DIVX_W,
        ST_MULY,
        ST_MULY_W,
        ST_DIVY,
        ST_DIVY_W,
        ST_MULP,
        ST_MULP_W,
        ST_OUT
    } seq_state_t;

endpackage

`default_nettype wire

// ----- rtl/lbmnm_muldiv.sv -----
// Shared shift-add multiplier and restoring divider on one adder.
`default_nettype none

module lbmnm_muldiv #(
    parameter int VALUE_WIDTH = lbmnm_pkg::VALUE_W_DEF
) (
    input  logic                                                    aclk,
    input  logic                                                    aresetn,
    input  lbmnm_pkg::md_ctrl_t                                     ctrl,
    input  logic [lbmnm_pkg::CFG_W-1:0]                             mul_a,
    input  logic [VALUE_WIDTH+lbmnm_pkg::ACC_GUARD-1:0]             mul_b,
    input  logic [VALUE_WIDTH+lbmnm_pkg::ACC_GUARD-1:0]             div_d,
    output lbmnm_pkg::md_stat_t                                     stat,
    output logic [lbmnm_pkg::CFG_W+VALUE_WIDTH+lbmnm_pkg::ACC_GUARD-1:0] prod,
    output logic [VALUE_WIDTH-1:0]                                  quot
);
    import lbmnm_pkg::*;

    localparam int ACC_W = VALUE_WIDTH + ACC_GUARD;
    localparam int PW    = CFG_W + ACC_W;
    localparam int HW    = PW - VALUE_WIDTH;
    localparam int DW    = ((HW > ACC_W) ? HW : ACC_W) + 1;
    localparam int STEPS = (CFG_W > VALUE_WIDTH) ? CFG_W : VALUE_WIDTH;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             ovf_reg, ovf_next;
    md_op_t           mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PW-1:0]    prod_reg, prod_next;
    logic [CFG_W-1:0] mpl_reg, mpl_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;

    logic [PW-1:0]    op_x, op_y;
    logic             sub;
    logic [PW:0]      sum;
    logic             ge;
    logic [DW-1:0]    div_x;

    assign div_x = {rem_reg[DW-2:0], quo_reg[VALUE_WIDTH-1]};

    // single adder: product step, division step or the quotient range check
    always_comb begin
        op_x = '0;
        op_y = '0;
        sub  = 1'b0;
        if (!busy_reg) begin
            op_x = PW'(prod_reg[PW-1:VALUE_WIDTH]);
            op_y = PW'(div_d);
            sub  = 1'b1;
        end else if (mode_reg == MD_MUL) begin
            op_x = {prod_reg[PW-2:0], 1'b0};
            op_y = mpl_reg[CFG_W-1] ? PW'(mul_b) : '0;
        end else begin
            op_x = PW'(div_x);
            op_y = PW'(div_d);
            sub  = 1'b1;
        end
        sum = {1'b0, op_x} + {1'b0, op_y ^ {PW{sub}}} + (PW+1)'(sub);
    end

    assign ge = sum[PW];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        prod_next = prod_reg;
        mpl_next  = mpl_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (!busy_reg) begin
            if (ctrl.start) begin
                mode_next = ctrl.op;
                if (ctrl.op == MD_MUL) begin
                    busy_next = 1'b1;
                    ovf_next  = 1'b0;
                    cnt_next  = CNT_W'(CFG_W);
                    prod_next = '0;
                    mpl_next  = mul_a;
                end else if (ge) begin
                    // quotient needs more than VALUE_WIDTH bits
                    done_next = 1'b1;
                    ovf_next  = 1'b1;
                end else begin
                    busy_next = 1'b1;
                    ovf_next  = 1'b0;
                    cnt_next  = CNT_W'(VALUE_WIDTH);
                    rem_next  = DW'(prod_reg[PW-1:VALUE_WIDTH]);
                    quo_next  = prod_reg[VALUE_WIDTH-1:0];
                end
            end
        end else begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            if (mode_reg == MD_MUL) begin
                prod_next = sum[PW-1:0];
                mpl_next  = {mpl_reg[CFG_W-2:0], 1'b0};
            end else begin
                rem_next = ge ? sum[DW-1:0] : div_x;
                quo_next = {quo_reg[VALUE_WIDTH-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            mode_reg <= MD_MUL;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        mpl_reg  <= mpl_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    assign stat = '{busy: busy_reg, done: done_reg, ovf: ovf_reg};
    assign prod = prod_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/lbm_node_moments.sv -----
// Top level: D2Q9 node moments (velocity, pressure, solute) per lattice node.
//
// Input stream carries one population per item; s_tlast marks the node's last
// item. Flow items (s_tuser func = 0) add to density and, by direction, to the
// x/y momentum; solute items add to the solute sum. Items are taken one per
// cycle while the node accumulates.
// After the last item the sequencer runs a shared unit with one adder: a
// shift-add multiply (one multiplier bit per cycle) and a restoring divide
// (one quotient bit per cycle). A node runs c*mx, /rho, c*my, /rho, rho*cs2,
// each a start state and a wait state ending on done, then the output state;
// when density is zero only rho*cs2 runs. s_tready stays low during that
// time; the result is valid when it returns. The result is held in an output
// register; the next node is accepted while it waits. A stalled receiver
// holds back the following node's result and, while that waits, the input
// of the node after it. Reset clears the sums, the output valid and restores
// the config defaults. Config writes take effect at once; the user must make
// them while the block is idle; the block itself does not enforce this.
`default_nettype none

module lbm_node_moments #(
    parameter int VALUE_WIDTH = lbmnm_pkg::VALUE_W_DEF,
    parameter int FRAC_BITS   = lbmnm_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       s_tdata,   // population
    input  logic [lbmnm_pkg::DIRECTION_W:0]        s_tuser,   // func, direction
    input  logic                                   s_tlast,   // last_of_node
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // velocity_x, velocity_y, node_pressure, solute_density
    output logic [((4*VALUE_WIDTH+7)/8)*8-1:0]     m_tdata,
    output logic [0:0]                             m_tuser,   // zero_density
    input  logic                                   cfg_wr_en,
    input  logic [lbmnm_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [lbmnm_pkg::CFG_W-1:0]            cfg_wdata
);
    import lbmnm_pkg::*;

    localparam int VW     = VALUE_WIDTH;
    localparam int ACC_W  = VW + ACC_GUARD;
    localparam int PW     = CFG_W + ACC_W;
    localparam int OUT_TW = ((4*VW+7)/8)*8;

    seq_state_t       state_reg, state_next;
    logic [CFG_W-1:0] lspeed_reg, cs_reg;
    logic [ACC_W-1:0] rho_reg, rho_next;
    logic [ACC_W-1:0] mx_reg, mx_next;
    logic [ACC_W-1:0] my_reg, my_next;
    logic [ACC_W-1:0] sol_reg, sol_next;
    logic [VW-1:0]    vx_reg, vx_next;
    logic [VW-1:0]    vy_reg, vy_next;
    logic             out_vld_reg, out_vld_next;
    logic [4*VW-1:0]  out_data_reg, out_data_next;
    logic             out_zero_reg, out_zero_next;

    md_ctrl_t         md_ctrl;
    md_stat_t         md_stat;
    logic [CFG_W-1:0] mul_a;
    logic [ACC_W-1:0] mul_b;
    logic [PW-1:0]    prod;
    logic [VW-1:0]    quot;

    logic             in_acc, out_load, rho_zero;
    logic             func;
    logic [DIRECTION_W-1:0] dir;
    logic [ACC_W-1:0] pop_ext;
    logic             add_x, sub_x, add_y, sub_y;
    logic [ACC_W-1:0] rho_mag, mx_mag, my_mag, sol_mag;
    logic [VW-1:0]    vel_sat, pres_sat, sol_sat;

    function automatic logic [ACC_W-1:0] acc_mag(input logic [ACC_W-1:0] v);
        return v[ACC_W-1] ? (~v + ACC_W'(1)) : v;
    endfunction

    function automatic logic [VW-1:0] sat_val(input logic neg, input logic big,
                                              input logic [VW-1:0] mag);
        logic [VW-1:0] lim;
        lim = mag;
        if (neg) begin
            if (big || (mag[VW-1] && (|mag[VW-2:0]))) begin
                lim = {1'b1, {(VW-1){1'b0}}};
            end
            return ~lim + VW'(1);
        end
        if (big || mag[VW-1]) begin
            lim = {1'b0, {(VW-1){1'b1}}};
        end
        return lim;
    endfunction

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lspeed_reg <= LATTICE_SPEED_RST;
            cs_reg     <= SOUND_SPEED_SQ_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_LATTICE_SPEED:  lspeed_reg <= cfg_wdata;
                CFG_SOUND_SPEED_SQ: cs_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign func    = s_tuser[0];
    assign dir     = s_tuser[DIRECTION_W:1];
    assign pop_ext = {{ACC_GUARD{s_tdata[VW-1]}}, s_tdata[VW-1:0]};

    always_comb begin
        add_x = 1'b0;
        sub_x = 1'b0;
        add_y = 1'b0;
        sub_y = 1'b0;
        case (dir)
            DIR_EAST:  add_x = 1'b1;
            DIR_NORTH: add_y = 1'b1;
            DIR_WEST:  sub_x = 1'b1;
            DIR_SOUTH: sub_y = 1'b1;
            DIR_NE: begin
                add_x = 1'b1;
                add_y = 1'b1;
            end
            DIR_NW: begin
                sub_x = 1'b1;
                add_y = 1'b1;
            end
            DIR_SW: begin
                sub_x = 1'b1;
                sub_y = 1'b1;
            end
            DIR_SE: begin
                add_x = 1'b1;
                sub_y = 1'b1;
            end
            default: ;
        endcase
    end

    assign rho_mag  = acc_mag(rho_reg);
    assign mx_mag   = acc_mag(mx_reg);
    assign my_mag   = acc_mag(my_reg);
    assign sol_mag  = acc_mag(sol_reg);
    assign rho_zero = (rho_reg == '0);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACC:    if (in_acc && s_tlast) state_next = ST_MULX;
            ST_MULX:   state_next = rho_zero ? ST_MULP : ST_MULX_W;
            ST_MULX_W: if (md_stat.done) state_next = ST_DIVX;
            ST_DIVX:   state_next = ST_DIVX_W;
            ST_DIVX_W: if (md_stat.done) state_next = ST_MULY;
            ST_MULY:   state_next = ST_MULY_W;
            ST_MULY_W: if (md_stat.done) state_next = ST_DIVY;
            ST_DIVY:   state_next = ST_DIVY_W;
            ST_DIVY_W: if (md_stat.done) state_next = ST_MULP;
            ST_MULP:   state_next = ST_MULP_W;
            ST_MULP_W: if (md_stat.done) state_next = ST_OUT;
            ST_OUT:    if (!out_vld_reg || m_tready) state_next = ST_ACC;
            default:   state_next = ST_ACC;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready      = 1'b0;
        md_ctrl.start = 1'b0;
        md_ctrl.op    = MD_MUL;
        mul_a         = lspeed_reg;
        mul_b         = rho_mag;
        out_load      = 1'b0;
        case (state_reg)
            ST_ACC: s_tready = 1'b1;
            ST_MULX: begin
                md_ctrl.start = !rho_zero;
                mul_b         = mx_mag;
            end
            ST_MULX_W: mul_b = mx_mag;
            ST_DIVX, ST_DIVY: begin
                md_ctrl.start = 1'b1;
                md_ctrl.op    = MD_DIV;
            end
            ST_MULY: begin
                md_ctrl.start = 1'b1;
                mul_b         = my_mag;
            end
            ST_MULY_W: mul_b = my_mag;
            ST_MULP: begin
                md_ctrl.start = 1'b1;
                mul_a         = cs_reg;
            end
            ST_MULP_W: mul_a = cs_reg;
            ST_OUT: out_load = !out_vld_reg || m_tready;
            default: ;
        endcase
    end

    assign in_acc = s_tvalid && s_tready;

    assign vel_sat  = sat_val((state_reg == ST_DIVX_W ? mx_reg[ACC_W-1] : my_reg[ACC_W-1])
                              ^ rho_reg[ACC_W-1], md_stat.ovf, quot);
    assign pres_sat = sat_val(rho_reg[ACC_W-1], |prod[PW-1:VW+FRAC_BITS],
                              prod[VW+FRAC_BITS-1:FRAC_BITS]);
    assign sol_sat  = sat_val(sol_reg[ACC_W-1], |sol_mag[ACC_W-1:VW], sol_mag[VW-1:0]);

    // datapath next values
    always_comb begin
        rho_next      = rho_reg;
        mx_next       = mx_reg;
        my_next       = my_reg;
        sol_next      = sol_reg;
        vx_next       = vx_reg;
        vy_next       = vy_reg;
        out_data_next = out_data_reg;
        out_zero_next = out_zero_reg;
        out_vld_next  = m_tready ? 1'b0 : out_vld_reg;
        if (in_acc) begin
            if (func) begin
                sol_next = sol_reg + pop_ext;
            end else begin
                rho_next = rho_reg + pop_ext;
                if (add_x) mx_next = mx_reg + pop_ext;
                if (sub_x) mx_next = mx_reg - pop_ext;
                if (add_y) my_next = my_reg + pop_ext;
                if (sub_y) my_next = my_reg - pop_ext;
            end
        end
        if (state_reg == ST_MULX && rho_zero) begin
            vx_next = '0;
            vy_next = '0;
        end
        if (state_reg == ST_DIVX_W && md_stat.done) vx_next = vel_sat;
        if (state_reg == ST_DIVY_W && md_stat.done) vy_next = vel_sat;
        if (out_load) begin
            out_vld_next  = 1'b1;
            out_data_next = {sol_sat, pres_sat, vy_reg, vx_reg};
            out_zero_next = rho_zero;
            rho_next      = '0;
            mx_next       = '0;
            my_next       = '0;
            sol_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACC;
            out_vld_reg <= 1'b0;
            rho_reg     <= '0;
            mx_reg      <= '0;
            my_reg      <= '0;
            sol_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            rho_reg     <= rho_next;
            mx_reg      <= mx_next;
            my_reg      <= my_next;
            sol_reg     <= sol_next;
        end
    end

    always_ff @(posedge aclk) begin
        vx_reg       <= vx_next;
        vy_reg       <= vy_next;
        out_data_reg <= out_data_next;
        out_zero_reg <= out_zero_next;
    end

    lbmnm_muldiv #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (md_ctrl),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .div_d   (rho_mag),
        .stat    (md_stat),
        .prod    (prod),
        .quot    (quot)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_TW'(out_data_reg);
    assign m_tuser  = out_zero_reg;

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        md_stat.busy |-> !s_tready)
        else $error("input taken while shared unit busy");

    a_sums_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (rho_reg == '0 && mx_reg == '0 && my_reg == '0 && sol_reg == '0))
        else $error("sums not cleared after node result");

    a_zero_vel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (out_data_reg[2*VW-1:0] == '0))
        else $error("nonzero velocity with zero density");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        md_stat.done |-> (state_reg == ST_MULX_W || state_reg == ST_DIVX_W ||
                          state_reg == ST_MULY_W || state_reg == ST_DIVY_W ||
                          state_reg == ST_MULP_W))
        else $error("shared unit finished outside a wait state");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench for lbm_node_moments: streams populations, predicts node moments.
module testbench;
    import lbmnm_pkg::*;

    localparam int VW             = VALUE_W_DEF;
    localparam int FB             = FRAC_BITS_DEF;
    localparam int ACC_W          = VW + ACC_GUARD;
    localparam int DATA_W         = ((VW + 7) / 8) * 8;
    localparam int RES_W          = ((4 * VW + 7) / 8) * 8;
    localparam int NODE_CYCLES    = 3 * CFG_W + 2 * VW + 12;
    localparam int SETTLE_CYCLES  = 2 * NODE_CYCLES;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEM_TARGET    = 1150;

    localparam logic FUNC_FLOW   = 1'b0;
    localparam logic FUNC_SOLUTE = 1'b1;

    localparam logic [VW-1:0] POP_MAX  = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] POP_MIN  = {1'b1, {(VW-1){1'b0}}};
    localparam logic [VW-1:0] POP_UNIT = VW'(1) << FB;

    typedef struct packed {
        logic                   func;
        logic [DIRECTION_W-1:0] dir;
        logic [VW-1:0]          pop;
        logic                   last;
    } population_t;

    typedef struct packed {
        logic [VW-1:0] vel_x;
        logic [VW-1:0] vel_y;
        logic [VW-1:0] pressure;
        logic [VW-1:0] solute;
        logic          zero_rho;
    } moments_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata;
    logic [DIRECTION_W:0]   s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [RES_W-1:0]       m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_W-1:0]       cfg_wdata;

    // predictor state
    logic [ACC_W-1:0] density_acc, mom_x_acc, mom_y_acc, solute_acc;
    logic [CFG_W-1:0] speed_q, cs2_q;
    moments_t         pending_moments[$];

    int  items_sent    = 0;
    int  nodes_checked = 0;
    int  zero_nodes    = 0;
    int  reg_writes    = 0;
    int  mismatches    = 0;
    int  quiet_cycles  = 0;
    int  hold_request  = 0;
    bit  no_idle       = 1'b0;

    lbm_node_moments #(
        .VALUE_WIDTH(VW),
        .FRAC_BITS  (FB)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ---------------- prediction ----------------

    function automatic logic [ACC_W-1:0] magnitude(input logic [ACC_W-1:0] v);
        return v[ACC_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [VW-1:0] clamp_signed(input logic neg, input logic [127:0] mag);
        logic [127:0] half;
        logic [127:0] t;
        half = 128'd1 << (VW - 1);
        if (neg) begin
            if (mag > half) mag = half;
            t = ~mag + 128'd1;
            return t[VW-1:0];
        end
        if (mag > half - 128'd1) mag = half - 128'd1;
        return mag[VW-1:0];
    endfunction

    function automatic logic [VW-1:0] scaled_velocity(input logic [ACC_W-1:0] mom,
                                                      input logic [ACC_W-1:0] rho);
        logic [127:0] num;
        logic [127:0] den;
        num = 128'(speed_q) * 128'(magnitude(mom));
        den = 128'(magnitude(rho));
        num = num / den;
        return clamp_signed(mom[ACC_W-1] ^ rho[ACC_W-1], num);
    endfunction

    task automatic absorb_population(input population_t it);
        logic [ACC_W-1:0] p;
        logic [127:0]     prod;
        moments_t         m;
        p = {{ACC_GUARD{it.pop[VW-1]}}, it.pop};
        if (it.func == FUNC_SOLUTE) begin
            solute_acc += p;
        end else begin
            density_acc += p;
            case (it.dir)
                DIR_EAST:  mom_x_acc += p;
                DIR_WEST:  mom_x_acc -= p;
                DIR_NORTH: mom_y_acc += p;
                DIR_SOUTH: mom_y_acc -= p;
                DIR_NE: begin
                    mom_x_acc += p;
                    mom_y_acc += p;
                end
                DIR_NW: begin
                    mom_x_acc -= p;
                    mom_y_acc += p;
                end
                DIR_SW: begin
                    mom_x_acc -= p;
                    mom_y_acc -= p;
                end
                DIR_SE: begin
                    mom_x_acc += p;
                    mom_y_acc -= p;
                end
                default: ;
            endcase
        end
        if (it.last) begin
            m.zero_rho = (density_acc == '0);
            if (m.zero_rho) begin
                m.vel_x = '0;
                m.vel_y = '0;
                zero_nodes++;
            end else begin
                m.vel_x = scaled_velocity(mom_x_acc, density_acc);
                m.vel_y = scaled_velocity(mom_y_acc, density_acc);
            end
            prod       = (128'(magnitude(density_acc)) * 128'(cs2_q)) >> FB;
            m.pressure = clamp_signed(density_acc[ACC_W-1], prod);
            m.solute   = clamp_signed(solute_acc[ACC_W-1], 128'(magnitude(solute_acc)));
            pending_moments.push_back(m);
            density_acc = '0;
            mom_x_acc   = '0;
            mom_y_acc   = '0;
            solute_acc  = '0;
        end
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input logic [VW-1:0] got,
                                   input logic [VW-1:0] want);
        mismatches++;
        if (mismatches <= 50)
            $display("ERROR node %0d: %s got %h want %h", nodes_checked, what, got, want);
    endtask

    always @(posedge aclk) begin : result_check
        moments_t want;
        logic [VW-1:0] got_x, got_y, got_p, got_s;
        if (aresetn && m_tvalid && m_tready) begin
            got_x = m_tdata[VW-1:0];
            got_y = m_tdata[2*VW-1:VW];
            got_p = m_tdata[3*VW-1:2*VW];
            got_s = m_tdata[4*VW-1:3*VW];
            if (pending_moments.size() == 0) begin
                report_mismatch("result with none pending, velocity_x", got_x, '0);
            end else begin
                want = pending_moments.pop_front();
                if (got_x !== want.vel_x) report_mismatch("velocity_x", got_x, want.vel_x);
                if (got_y !== want.vel_y) report_mismatch("velocity_y", got_y, want.vel_y);
                if (got_p !== want.pressure) report_mismatch("node_pressure", got_p, want.pressure);
                if (got_s !== want.solute) report_mismatch("solute_density", got_s, want.solute);
                if (m_tuser[0] !== want.zero_rho)
                    report_mismatch("zero_density", VW'(m_tuser[0]), VW'(want.zero_rho));
            end
            nodes_checked++;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("lbm_node_moments: mismatch");
            $finish;
        end
    end

    // ---------------- drivers ----------------

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial begin : receiver
        int run_left;
        int stall_left;
        int hold_left;
        run_left   = 0;
        stall_left = 0;
        hold_left  = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (run_left > 0 || no_idle) begin
                m_tready <= 1'b1;
                if (run_left > 0) run_left--;
            end else begin
                run_left   = $urandom_range(1, 24);
                stall_left = idle_gap();
                if (stall_left > 0) begin
                    m_tready <= 1'b0;
                    stall_left--;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    task automatic send_item(input population_t it);
        int gap;
        gap = idle_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(it.pop);
        s_tuser  <= {it.dir, it.func};
        s_tlast  <= it.last;
        do @(posedge aclk); while (!s_tready);
        absorb_population(it);
        items_sent++;
    endtask

    function automatic population_t make_item(input logic func, input int dir,
                                              input logic [VW-1:0] pop, input logic last);
        population_t it;
        it.func = func;
        it.dir  = DIRECTION_W'(dir);
        it.pop  = pop;
        it.last = last;
        return it;
    endfunction

    task automatic drain_results(input int extra);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_moments.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_LATTICE_SPEED:  speed_q = value;
            CFG_SOUND_SPEED_SQ: cs2_q   = value;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_config(input logic [CFG_W-1:0] speed, input logic [CFG_W-1:0] cs2);
        drain_results(SETTLE_CYCLES);
        write_register(CFG_LATTICE_SPEED, speed);
        write_register(CFG_SOUND_SPEED_SQ, cs2);
    endtask

    // ---------------- stimulus ----------------

    function automatic logic [VW-1:0] edge_pop();
        case ($urandom_range(0, 7))
            0:       return POP_MAX;
            1:       return POP_MIN;
            2:       return '0;
            3:       return '1;
            4, 5:    return VW'($urandom);
            default: return VW'($urandom_range(0, 2 * POP_UNIT)) - POP_UNIT;
        endcase
    endfunction

    function automatic logic [VW-1:0] physical_pop(input bit wild);
        if (wild || $urandom_range(0, 19) == 0) return VW'($urandom);
        return VW'($urandom_range(0, POP_UNIT / 4)) - VW'(POP_UNIT / 64);
    endfunction

    // all nine flow directions in shuffled order, zero to three solute items mixed in
    task automatic send_physical_node();
        population_t node_q[$];
        int order[9];
        int j, t, n_sol;
        bit wild;
        wild = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < 9; i++) order[i] = i;
        for (int i = 8; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < 9; i++)
            node_q.push_back(make_item(FUNC_FLOW, order[i], physical_pop(wild), 1'b0));
        n_sol = $urandom_range(0, 3);
        for (int i = 0; i < n_sol; i++)
            node_q.insert($urandom_range(0, node_q.size()),
                          make_item(FUNC_SOLUTE, $urandom_range(0, 15),
                                    physical_pop(wild), 1'b0));
        node_q[node_q.size()-1].last = 1'b1;
        foreach (node_q[i]) send_item(node_q[i]);
    endtask

    task automatic send_noise_node();
        int len;
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
            send_item(make_item(1'($urandom_range(0, 1)), $urandom_range(0, 15),
                                edge_pop(), i == len - 1));
    endtask

    task automatic run_random(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 80) send_physical_node();
            else send_noise_node();
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_reg_value(input logic [CFG_W-1:0] typical);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return typical;
            3:       return CFG_W'($urandom_range(0, 4 * 65536));
            default: return CFG_W'($urandom);
        endcase
    endfunction

    // ---------------- tests ----------------

    task automatic test_directions();
        for (int d = 0; d <= 8; d++)
            send_item(make_item(FUNC_FLOW, d, VW'(d + 1) << 12, d == 8));
        for (int d = 9; d <= 15; d++)
            send_item(make_item(FUNC_FLOW, d, POP_UNIT, 1'b0));
        send_item(make_item(FUNC_SOLUTE, DIR_NE, POP_UNIT >> 1, 1'b1));
    endtask

    task automatic test_zero_density();
        send_item(make_item(FUNC_FLOW, DIR_EAST, VW'(100), 1'b0));
        send_item(make_item(FUNC_FLOW, DIR_WEST, -VW'(100), 1'b1));
        send_item(make_item(FUNC_SOLUTE, DIR_REST, VW'(32'h12345), 1'b1));
    endtask

    task automatic test_saturation();
        send_item(make_item(FUNC_FLOW, DIR_EAST, POP_MAX, 1'b0));
        send_item(make_item(FUNC_FLOW, DIR_REST, POP_MIN, 1'b0));
        send_item(make_item(FUNC_SOLUTE, DIR_SE, POP_MAX, 1'b0));
        send_item(make_item(FUNC_SOLUTE, DIR_SW, POP_MAX, 1'b1));
        send_item(make_item(FUNC_FLOW, DIR_SOUTH, POP_MIN, 1'b1));
    endtask

    task automatic test_config_extremes();
        apply_config('0, '0);
        run_random(130);
        apply_config('1, '1);
        run_random(130);
        no_idle = 1'b1;
        apply_config(CFG_W'(1), CFG_W'(1));
        run_random(130);
        no_idle = 1'b0;
        apply_config(CFG_W'(32'h0002_0000), SOUND_SPEED_SQ_RST);
        run_random(130);
        apply_config(CFG_W'($urandom), CFG_W'($urandom));
        run_random(130);
        apply_config(LATTICE_SPEED_RST, SOUND_SPEED_SQ_RST);
        run_random(130);
    endtask

    task automatic test_receiver_hold();
        no_idle      = 1'b1;
        hold_request = HOLD_CYCLES;
        repeat (5) send_physical_node();
        no_idle = 1'b0;
        drain_results(0);
        repeat (3) send_physical_node();
    endtask

    task automatic test_random_traffic();
        int chunk;
        while (items_sent < ITEM_TARGET) begin
            chunk = ITEM_TARGET - items_sent;
            if (chunk > 110) chunk = 110;
            apply_config(pick_reg_value(LATTICE_SPEED_RST), pick_reg_value(SOUND_SPEED_SQ_RST));
            no_idle = ($urandom_range(0, 3) == 0);
            run_random(chunk);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        s_tlast     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = CFG_LATTICE_SPEED;
        cfg_wdata   = '0;
        density_acc = '0;
        mom_x_acc   = '0;
        mom_y_acc   = '0;
        solute_acc  = '0;
        speed_q     = LATTICE_SPEED_RST;
        cs2_q       = SOUND_SPEED_SQ_RST;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directions();
        test_zero_density();
        test_saturation();
        test_config_extremes();
        test_receiver_hold();
        test_random_traffic();

        drain_results(SETTLE_CYCLES);
        if (pending_moments.size() != 0)
            report_mismatch("expected results never arrived, count", '0,
                            VW'(pending_moments.size()));

        $display("Covered %0d items over %0d nodes, %0d of them with zero density.",
                 items_sent, nodes_checked, zero_nodes);
        $display("%0d register writes incl. zero and all-ones; one %0d-cycle receiver hold.",
                 reg_writes, HOLD_CYCLES);
        if (mismatches == 0)
            $display("lbm_node_moments: match");
        else
            $display("lbm_node_moments: mismatch");
        $finish;
    end

endmodule
